// ----- rtl/core/vpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Variable partition allocator package
// Shared types, widths and codes for the allocator and its channels.
// ----------------------------------------------------------------------------
package vpa_pkg;

    localparam int TOTAL_UNITS    = 1024;
    localparam int MAX_PARTITIONS = 64;
    localparam int IDX_W          = $clog2(MAX_PARTITIONS);
    localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);
    localparam int UNIT_W         = 16;
    localparam int TASK_W         = 8;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_SPARE = 2'd3
    } policy_t;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_NO_TASK = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE,
        S_WR1,
        S_WR2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [UNIT_W-1:0] start;
        logic [UNIT_W-1:0] size;
        logic              used;
        logic [TASK_W-1:0] owner;
    } part_t;

endpackage

// ----- rtl/core/vpa_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator channel interfaces
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface vpa_req_if import vpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [TASK_W-1:0] task_id;
    logic [UNIT_W-1:0] size;

    modport source (output valid, op, task_id, size, input ready);
    modport sink   (input valid, op, task_id, size, output ready);
endinterface

interface vpa_rsp_if import vpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [UNIT_W-1:0] address;
    logic [CNT_W-1:0]  partition_count;

    modport source (output valid, status, address, partition_count, input ready);
    modport sink   (input valid, status, address, partition_count, output ready);
endinterface

// ----- rtl/core/variable_partition_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Variable partition allocator
// Address-ordered partition table in a synchronous RAM with first, best and
// worst fit allocation, splitting, release and merging of free neighbors.
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  req       in         op, task_id, size
//  rsp       out        status, address, partition_count
//  cfg       in         cfg_we, cfg_data (fit policy)
//
//  A request scans all N table entries and then decides.
//  When the table changes, a shift pass moves the entries behind the change,
//  and one or two table writes follow; the table RAM has one read and one
//  write per cycle.
//  After reset the initial free entry is written before req.ready rises.
//  One request is handled at a time; a held response stalls only at the end.
module variable_partition_allocator_top
    import vpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_data,
    vpa_req_if.sink     req,
    vpa_rsp_if.source   rsp
);

    part_t             mem [MAX_PARTITIONS];
    part_t             rdata_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    part_t             mem_wdata;

    state_t            state_reg, state_next;
    logic [1:0]        policy_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_new_reg;

    logic              op_reg;
    logic [TASK_W-1:0] task_reg;
    logic [UNIT_W-1:0] size_reg;

    logic [CNT_W-1:0]  scan_idx_reg;
    logic              rvalid_reg;
    logic [IDX_W-1:0]  ridx_reg;

    logic              found_reg;
    logic [IDX_W-1:0]  sel_idx_reg;
    logic [UNIT_W-1:0] sel_start_reg, sel_size_reg;
    logic              last_used_reg;
    logic [UNIT_W-1:0] last_start_reg, last_size_reg;
    logic              prev_free_reg;
    logic [UNIT_W-1:0] prev_start_reg, prev_size_reg;
    logic              want_next_reg, next_free_reg;
    logic [UNIT_W-1:0] next_size_reg;

    logic [IDX_W-1:0]  mv_src_reg, mv_dst_reg, pend_dst_reg;
    logic [CNT_W-1:0]  mv_left_reg;
    logic              mv_up_reg, pend_reg;

    logic [IDX_W-1:0]  wr1_addr_reg, wr2_addr_reg;
    part_t             wr1_data_reg, wr2_data_reg;
    logic              wr2_en_reg;
    status_t           st_reg;
    logic [UNIT_W-1:0] addr_reg;

    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [UNIT_W-1:0] out_addr_reg;
    logic [CNT_W-1:0]  out_cnt_reg;

    logic              accept;
    logic              scan_issue;
    logic              scan_last;
    logic              cand;
    logic              better;
    logic              move_done;
    logic              done_fire;

    assign accept     = req.valid && req.ready;
    assign scan_issue = (state_reg == S_SCAN) && (scan_idx_reg < cnt_reg);
    assign scan_last  = rvalid_reg && ({1'b0, ridx_reg} == cnt_reg - CNT_W'(1));
    assign move_done  = (mv_left_reg == '0) && !pend_reg;
    assign done_fire  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    assign cand = !rdata_reg.used && (rdata_reg.size >= size_reg);
    always_comb
    begin
        case (policy_reg)
            POL_BEST:  better = rdata_reg.size < sel_size_reg;
            POL_WORST: better = rdata_reg.size > sel_size_reg;
            default:   better = 1'b0;
        endcase
    end

    assign rd_addr = (state_reg == S_SCAN) ? scan_idx_reg[IDX_W-1:0] : mv_src_reg;

    // Table RAM: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pend_dst_reg;
        mem_wdata = rdata_reg;
        unique case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = '{start: '0, size: UNIT_W'(TOTAL_UNITS), used: 1'b0, owner: '0};
            end
            S_MOVE:
            begin
                mem_we = pend_reg;
            end
            S_WR1:
            begin
                mem_we    = 1'b1;
                mem_waddr = wr1_addr_reg;
                mem_wdata = wr1_data_reg;
            end
            S_WR2:
            begin
                mem_we    = 1'b1;
                mem_waddr = wr2_addr_reg;
                mem_wdata = wr2_data_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A request changes the table unless it fails one of the checks.
    function automatic logic st_next_ok();
        logic ok;
        if (op_reg == OP_ALLOC)
        begin
            ok = found_reg && (size_reg != '0)
                 && !((sel_size_reg > size_reg) && (cnt_reg == CNT_W'(MAX_PARTITIONS)));
        end
        else
        begin
            ok = found_reg;
        end
        return ok;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        unique case (state_reg)
            S_INIT:   state_next = S_IDLE;
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:   if (scan_last) state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (st_next_ok())
                begin
                    state_next = S_MOVE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MOVE:   if (move_done) state_next = S_WR1;
            S_WR1:    state_next = wr2_en_reg ? S_WR2 : S_DONE;
            S_WR2:    state_next = S_DONE;
            S_DONE:   if (done_fire) state_next = S_IDLE;
            default:  state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POL_WORST;
            cnt_reg       <= CNT_W'(1);
            out_valid_reg <= 1'b0;
            rvalid_reg    <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                policy_reg <= cfg_data;
            end
            rvalid_reg <= scan_issue;
            if (state_reg == S_MOVE)
            begin
                pend_reg <= mv_left_reg != '0;
            end
            else
            begin
                pend_reg <= 1'b0;
            end
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_new_reg;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= scan_idx_reg[IDX_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg        <= req.op;
                task_reg      <= req.task_id;
                size_reg      <= req.size;
                scan_idx_reg  <= '0;
                found_reg     <= 1'b0;
                want_next_reg <= 1'b0;
                next_free_reg <= 1'b0;
                last_used_reg <= 1'b1;
            end
            S_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
                if (rvalid_reg)
                begin
                    last_used_reg  <= rdata_reg.used;
                    last_start_reg <= rdata_reg.start;
                    last_size_reg  <= rdata_reg.size;
                    if (op_reg == OP_ALLOC)
                    begin
                        if (cand && (!found_reg || better))
                        begin
                            found_reg     <= 1'b1;
                            sel_idx_reg   <= ridx_reg;
                            sel_start_reg <= rdata_reg.start;
                            sel_size_reg  <= rdata_reg.size;
                        end
                    end
                    else if (want_next_reg)
                    begin
                        want_next_reg <= 1'b0;
                        next_free_reg <= !rdata_reg.used;
                        next_size_reg <= rdata_reg.size;
                    end
                    else if (!found_reg && rdata_reg.used && rdata_reg.owner == task_reg)
                    begin
                        found_reg      <= 1'b1;
                        want_next_reg  <= 1'b1;
                        sel_idx_reg    <= ridx_reg;
                        sel_start_reg  <= rdata_reg.start;
                        sel_size_reg   <= rdata_reg.size;
                        prev_free_reg  <= (ridx_reg != '0) && !last_used_reg;
                        prev_start_reg <= last_start_reg;
                        prev_size_reg  <= last_size_reg;
                    end
                end
            end
            S_DECIDE:
            begin
                wr2_en_reg  <= 1'b0;
                mv_left_reg <= '0;
                addr_reg    <= '0;
                cnt_new_reg <= cnt_reg;
                if (op_reg == OP_ALLOC)
                begin
                    if (!found_reg || size_reg == '0)
                    begin
                        st_reg <= ST_NO_FIT;
                    end
                    else if (sel_size_reg > size_reg)
                    begin
                        if (cnt_reg == CNT_W'(MAX_PARTITIONS))
                        begin
                            st_reg <= ST_FULL;
                        end
                        else
                        begin
                            st_reg       <= ST_OK;
                            addr_reg     <= sel_start_reg;
                            cnt_new_reg  <= cnt_reg + CNT_W'(1);
                            mv_up_reg    <= 1'b1;
                            mv_src_reg   <= IDX_W'(cnt_reg - CNT_W'(1));
                            mv_dst_reg   <= IDX_W'(cnt_reg);
                            mv_left_reg  <= cnt_reg - CNT_W'(1) - {1'b0, sel_idx_reg};
                            wr1_addr_reg <= sel_idx_reg + IDX_W'(1);
                            wr1_data_reg <= '{start: sel_start_reg + size_reg,
                                              size: sel_size_reg - size_reg,
                                              used: 1'b0, owner: '0};
                            wr2_en_reg   <= 1'b1;
                            wr2_addr_reg <= sel_idx_reg;
                            wr2_data_reg <= '{start: sel_start_reg, size: size_reg,
                                              used: 1'b1, owner: task_reg};
                        end
                    end
                    else
                    begin
                        st_reg       <= ST_OK;
                        addr_reg     <= sel_start_reg;
                        wr1_addr_reg <= sel_idx_reg;
                        wr1_data_reg <= '{start: sel_start_reg, size: sel_size_reg,
                                          used: 1'b1, owner: task_reg};
                    end
                end
                else if (!found_reg)
                begin
                    st_reg <= ST_NO_TASK;
                end
                else
                begin
                    st_reg    <= ST_OK;
                    mv_up_reg <= 1'b0;
                    if (prev_free_reg && next_free_reg)
                    begin
                        cnt_new_reg  <= cnt_reg - CNT_W'(2);
                        mv_src_reg   <= sel_idx_reg + IDX_W'(2);
                        mv_dst_reg   <= sel_idx_reg;
                        mv_left_reg  <= cnt_reg - {1'b0, sel_idx_reg} - CNT_W'(2);
                        wr1_addr_reg <= sel_idx_reg - IDX_W'(1);
                        wr1_data_reg <= '{start: prev_start_reg,
                                          size: prev_size_reg + sel_size_reg + next_size_reg,
                                          used: 1'b0, owner: '0};
                    end
                    else if (prev_free_reg)
                    begin
                        cnt_new_reg  <= cnt_reg - CNT_W'(1);
                        mv_src_reg   <= sel_idx_reg + IDX_W'(1);
                        mv_dst_reg   <= sel_idx_reg;
                        mv_left_reg  <= cnt_reg - {1'b0, sel_idx_reg} - CNT_W'(1);
                        wr1_addr_reg <= sel_idx_reg - IDX_W'(1);
                        wr1_data_reg <= '{start: prev_start_reg,
                                          size: prev_size_reg + sel_size_reg,
                                          used: 1'b0, owner: '0};
                    end
                    else if (next_free_reg)
                    begin
                        cnt_new_reg  <= cnt_reg - CNT_W'(1);
                        mv_src_reg   <= sel_idx_reg + IDX_W'(2);
                        mv_dst_reg   <= sel_idx_reg + IDX_W'(1);
                        mv_left_reg  <= cnt_reg - {1'b0, sel_idx_reg} - CNT_W'(2);
                        wr1_addr_reg <= sel_idx_reg;
                        wr1_data_reg <= '{start: sel_start_reg,
                                          size: sel_size_reg + next_size_reg,
                                          used: 1'b0, owner: '0};
                    end
                    else
                    begin
                        wr1_addr_reg <= sel_idx_reg;
                        wr1_data_reg <= '{start: sel_start_reg, size: sel_size_reg,
                                          used: 1'b0, owner: '0};
                    end
                end
            end
            S_MOVE:
            begin
                // Each cycle reads one source entry; its data is written in the following cycle.
                if (mv_left_reg != '0)
                begin
                    pend_dst_reg <= mv_dst_reg;
                    mv_left_reg  <= mv_left_reg - CNT_W'(1);
                    if (mv_up_reg)
                    begin
                        mv_src_reg <= mv_src_reg - IDX_W'(1);
                        mv_dst_reg <= mv_dst_reg - IDX_W'(1);
                    end
                    else
                    begin
                        mv_src_reg <= mv_src_reg + IDX_W'(1);
                        mv_dst_reg <= mv_dst_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (done_fire)
        begin
            out_status_reg <= st_reg;
            out_addr_reg   <= addr_reg;
            out_cnt_reg    <= cnt_new_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.address         = out_addr_reg;
    assign rsp.partition_count = out_cnt_reg;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) && (cnt_reg <= CNT_W'(MAX_PARTITIONS)))
        else $error("partition count out of range");

    a_cnt_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> $past(state_reg == S_DONE))
        else $error("partition count changed outside completion");

    a_move_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE && pend_reg && mv_left_reg != '0)
        |-> (mv_src_reg != pend_dst_reg))
        else $error("move reads the entry being written");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SCAN))
        else $error("accepted request did not start a scan");
`endif

endmodule

// ----- test/variable_partition_allocator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Variable partition allocator testbench
// Drives allocate and release requests under every fit policy, predicts each
// response from a local copy of the partition table and checks it field by
// field.
// ----------------------------------------------------------------------------
module variable_partition_allocator_top_tb;
    import vpa_pkg::*;

    typedef struct {
        status_t           status;
        logic [UNIT_W-1:0] address;
        logic [CNT_W-1:0]  partition_count;
    } alloc_rsp_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_data;

    vpa_req_if req_ch ();
    vpa_rsp_if rsp_ch ();

    variable_partition_allocator_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch.sink),
        .rsp      (rsp_ch.source)
    );

    // Model of the partition table.
    logic [UNIT_W-1:0] mdl_start [MAX_PARTITIONS];
    logic [UNIT_W-1:0] mdl_size  [MAX_PARTITIONS];
    logic              mdl_used  [MAX_PARTITIONS];
    logic [TASK_W-1:0] mdl_owner [MAX_PARTITIONS];
    int                mdl_count;
    policy_t           mdl_policy;

    alloc_rsp_t pending_rsp [$];
    int         error_count;
    bit         idle_enable;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic table_reset();
        for (int k = 0; k < MAX_PARTITIONS; k++)
        begin
            mdl_start[k] = '0;
            mdl_size[k]  = '0;
            mdl_used[k]  = 1'b0;
            mdl_owner[k] = '0;
        end
        mdl_size[0] = UNIT_W'(TOTAL_UNITS);
        mdl_count   = 1;
        mdl_policy  = POL_WORST;
    endtask

    task automatic table_open(input int pos);
        for (int k = mdl_count; k > pos; k--)
        begin
            mdl_start[k] = mdl_start[k-1];
            mdl_size[k]  = mdl_size[k-1];
            mdl_used[k]  = mdl_used[k-1];
            mdl_owner[k] = mdl_owner[k-1];
        end
        mdl_count++;
    endtask

    task automatic table_close(input int pos);
        for (int k = pos; k + 1 < mdl_count; k++)
        begin
            mdl_start[k] = mdl_start[k+1];
            mdl_size[k]  = mdl_size[k+1];
            mdl_used[k]  = mdl_used[k+1];
            mdl_owner[k] = mdl_owner[k+1];
        end
        mdl_count--;
        mdl_start[mdl_count] = '0;
        mdl_size[mdl_count]  = '0;
        mdl_used[mdl_count]  = 1'b0;
        mdl_owner[mdl_count] = '0;
    endtask

    task automatic predict_request(input op_t op, input logic [TASK_W-1:0] tid,
                                   input logic [UNIT_W-1:0] units,
                                   output alloc_rsp_t r);
        int  sel;
        bit  found;
        sel   = 0;
        found = 0;
        r.status  = ST_OK;
        r.address = '0;
        if (op == OP_ALLOC)
        begin
            if (units == 0)
                r.status = ST_NO_FIT;
            else
            begin
                for (int k = 0; k < mdl_count; k++)
                begin
                    if (mdl_used[k] || mdl_size[k] < units)
                        continue;
                    if (!found)
                    begin
                        sel   = k;
                        found = 1;
                        if (mdl_policy != POL_BEST && mdl_policy != POL_WORST)
                            break;
                    end
                    else if (mdl_policy == POL_BEST && mdl_size[k] < mdl_size[sel])
                        sel = k;
                    else if (mdl_policy == POL_WORST && mdl_size[k] > mdl_size[sel])
                        sel = k;
                end
                if (!found)
                    r.status = ST_NO_FIT;
                else if (mdl_size[sel] > units && mdl_count >= MAX_PARTITIONS)
                    r.status = ST_FULL;
                else
                begin
                    if (mdl_size[sel] > units)
                    begin
                        table_open(sel + 1);
                        mdl_start[sel+1] = mdl_start[sel] + units;
                        mdl_size[sel+1]  = mdl_size[sel] - units;
                        mdl_used[sel+1]  = 1'b0;
                        mdl_owner[sel+1] = '0;
                        mdl_size[sel]    = units;
                    end
                    mdl_used[sel]  = 1'b1;
                    mdl_owner[sel] = tid;
                    r.address      = mdl_start[sel];
                end
            end
        end
        else
        begin
            sel = mdl_count;
            for (int k = 0; k < mdl_count; k++)
                if (mdl_used[k] && mdl_owner[k] == tid)
                begin
                    sel = k;
                    break;
                end
            if (sel >= mdl_count)
                r.status = ST_NO_TASK;
            else
            begin
                mdl_used[sel]  = 1'b0;
                mdl_owner[sel] = '0;
                if (sel > 0 && !mdl_used[sel-1])
                begin
                    mdl_size[sel-1] = mdl_size[sel-1] + mdl_size[sel];
                    table_close(sel);
                    sel--;
                end
                if (sel + 1 < mdl_count && !mdl_used[sel+1])
                begin
                    mdl_size[sel] = mdl_size[sel] + mdl_size[sel+1];
                    table_close(sel + 1);
                end
            end
        end
        r.partition_count = CNT_W'(mdl_count);
    endtask

    // The request stays valid after acceptance until the next call drives the
    // next one or an idle or drain deasserts it.
    task automatic send_request(input op_t op, input logic [TASK_W-1:0] tid,
                                input logic [UNIT_W-1:0] units);
        alloc_rsp_t r;
        while (idle_enable && $urandom_range(99) < 25)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.op      <= op;
        req_ch.task_id <= tid;
        req_ch.size    <= units;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_request(op, tid, units, r);
        pending_rsp.push_back(r);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0 && guard < 100_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4 * MAX_PARTITIONS) @(posedge clk);
    endtask

    task automatic write_policy(input policy_t pol);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= pol;
        @(posedge clk);
        cfg_we   <= 1'b0;
        mdl_policy = pol;
    endtask

    // Response checker with random backpressure when idle_enable is set.
    always @(posedge clk)
    begin
        alloc_rsp_t exp_rsp;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected response status=%0d address=%0d count=%0d",
                         $time, rsp_ch.status, rsp_ch.address, rsp_ch.partition_count);
                error_count++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp_ch.status !== exp_rsp.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_rsp.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.address !== exp_rsp.address)
                begin
                    $display("%0t: address expected %0d actual %0d",
                             $time, exp_rsp.address, rsp_ch.address);
                    error_count++;
                end
                if (rsp_ch.partition_count !== exp_rsp.partition_count)
                begin
                    $display("%0t: partition_count expected %0d actual %0d",
                             $time, exp_rsp.partition_count, rsp_ch.partition_count);
                    error_count++;
                end
            end
        end
        rsp_ch.ready <= idle_enable ? ($urandom_range(99) >= 25) : 1'b1;
    end

    task automatic test_directed();
        send_request(OP_ALLOC, 8'd1, 16'd0);
        send_request(OP_RELEASE, 8'd9, 16'd0);
        send_request(OP_ALLOC, 8'd0, 16'd1);
        send_request(OP_ALLOC, 8'd255, 16'd100);
        send_request(OP_ALLOC, 8'd2, 16'hFFFF);
        send_request(OP_ALLOC, 8'd3, 16'd923);
        send_request(OP_ALLOC, 8'd4, 16'd1);
        send_request(OP_RELEASE, 8'd255, 16'hFFFF);
        send_request(OP_RELEASE, 8'd0, 16'd0);
        send_request(OP_RELEASE, 8'd3, 16'd0);
        send_request(OP_RELEASE, 8'd4, 16'd0);
        send_request(OP_ALLOC, 8'd5, 16'd1024);
        send_request(OP_RELEASE, 8'd5, 16'd0);
    endtask

    // Fills the table with one-unit blocks so the full-table case shows up,
    // then frees alternate blocks and probes an exact fit at the limit.
    task automatic test_table_full();
        for (int k = 0; k < MAX_PARTITIONS; k++)
            send_request(OP_ALLOC, TASK_W'(k + 1), 16'd1);
        send_request(OP_ALLOC, 8'd200, 16'd1);
        for (int k = 0; k < 8; k += 2)
            send_request(OP_RELEASE, TASK_W'(k + 1), 16'd0);
        send_request(OP_ALLOC, 8'd201, 16'd1);
        for (int k = 0; k < MAX_PARTITIONS + 2; k++)
            send_request(OP_RELEASE, TASK_W'(k + 1), 16'd0);
        send_request(OP_RELEASE, 8'd200, 16'd0);
        send_request(OP_RELEASE, 8'd201, 16'd0);
    endtask

    task automatic test_random(input int n);
        logic [UNIT_W-1:0] units;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0:       units = 16'($urandom());
                1:       units = 16'd0;
                2, 3:    units = 16'($urandom_range(200, 1));
                default: units = 16'($urandom_range(40, 1));
            endcase
            if ($urandom_range(99) < 55)
                send_request(OP_ALLOC, 8'($urandom_range(24)), units);
            else
                send_request(OP_RELEASE, 8'($urandom_range(24)), 16'($urandom()));
            if (k % 100 == 0)
                send_request(OP_ALLOC, 8'($urandom()), 16'($urandom()));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = 2'd0;
        req_ch.valid   = 1'b0;
        req_ch.op      = 1'b0;
        req_ch.task_id = '0;
        req_ch.size    = '0;
        error_count    = 0;
        idle_enable    = 1'b0;
        table_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_policy(POL_FIRST);
        test_directed();
        test_table_full();
        idle_enable = 1'b1;
        test_random(350);
        // The sender holds off here until every response is back.
        write_policy(POL_BEST);
        test_random(350);
        write_policy(POL_SPARE);
        test_random(300);
        write_policy(POL_WORST);
        idle_enable = 1'b0;
        test_random(150);
        idle_enable = 1'b1;
        test_table_full();
        test_random(100);

        wait_drained();
        if (pending_rsp.size() == 0 && error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
